/* src/pkat_pkg.sv */
// ----------------------------------------------------------------------------
// pkat_pkg
// Shared types and constants of the pair-keyed accumulate table.
// ----------------------------------------------------------------------------
package pkat_pkg;

  localparam int ID_W            = 8;   // width of the id ports
  localparam int AMOUNT_W        = 16;
  localparam int VALUE_W         = 22;
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_ID_BITS     = 8;

  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = {AMOUNT_W{1'b1}};
  localparam logic [VALUE_W-1:0]  VALUE_MAX  = {VALUE_W{1'b1}};

  typedef enum logic [2:0] {
    FUNC_CLEAR    = 3'd0,
    FUNC_ADD      = 3'd1,
    FUNC_LOOKUP   = 3'd2,
    FUNC_LIST_SRC = 3'd3,
    FUNC_LIST_DST = 3'd4,
    FUNC_SUM_SRC  = 3'd5,
    FUNC_SUM_DST  = 3'd6,
    FUNC_NOP      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

/* src/pkat_ram.sv */
// ----------------------------------------------------------------------------
// pkat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pkat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pair_keyed_accumulate_table_top.sv */
// ----------------------------------------------------------------------------
// pair_keyed_accumulate_table_top
// Table of (source, destination) keyed amounts with add, lookup, list and sum.
// ----------------------------------------------------------------------------
// One operation runs at a time. An operation that scans accepts the word,
// reads the stored entries one after another through the single read port of
// the entry RAM, and then hands over the final result; add and lookup stop at
// the first matching entry, and clear and an operation on an empty table skip
// the scan. A list stalls its scan while the downstream side holds off a
// result. The final result sits in an output register, so the next word is
// accepted while it waits. Entries are kept in append order; no clearing pass
// is needed after reset.
module pair_keyed_accumulate_table_top
  import pkat_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          func,
  input  logic [ID_W-1:0]     src_region,
  input  logic [ID_W-1:0]     dst_region,
  input  logic [AMOUNT_W-1:0] amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     out_src,
  output logic [ID_W-1:0]     out_dst,
  output logic [VALUE_W-1:0]  value,
  output logic [1:0]          status,
  output logic                last
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 2 * ID_BITS + AMOUNT_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t               state, state_next;
  func_t                op;
  logic [ID_BITS-1:0]   q_src, q_dst;
  logic [AMOUNT_W-1:0]  q_amount;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     scan_idx, scan_idx_next;

  // Pending result: the one that goes out next.
  logic [ID_BITS-1:0]   res_src, res_src_next;
  logic [ID_BITS-1:0]   res_dst, res_dst_next;
  logic [VALUE_W-1:0]   res_value, res_value_next;
  status_t              res_status, res_status_next;
  logic                 res_hit, res_hit_next;

  logic                 out_load;
  logic [ID_BITS-1:0]   ld_src, ld_dst;
  logic [VALUE_W-1:0]   ld_value;
  status_t              ld_status;
  logic                 ld_last;

  logic                 accept, out_free;
  logic [ID_BITS-1:0]   in_src_key, in_dst_key;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [ID_BITS-1:0]   ent_src, ent_dst;
  logic [AMOUNT_W-1:0]  ent_amt;

  logic                 hit_src, hit_dst, hit_sel, at_end;
  logic [AMOUNT_W:0]    amt_sum;
  logic [AMOUNT_W-1:0]  amt_sat;
  logic [VALUE_W:0]     tot_sum;
  logic [VALUE_W-1:0]   tot_sat;

  pkat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign in_src_key = ID_BITS'(src_region);
  assign in_dst_key = ID_BITS'(dst_region);

  assign {ent_src, ent_dst, ent_amt} = ram_rdata;
  assign hit_src = (ent_src == q_src);
  assign hit_dst = (ent_dst == q_dst);
  assign hit_sel = (op == FUNC_LIST_SRC || op == FUNC_SUM_SRC) ? hit_src : hit_dst;
  assign at_end  = (CNT_W'(scan_idx) == count - CNT_W'(1));

  assign amt_sum = {1'b0, ent_amt} + {1'b0, q_amount};
  assign amt_sat = amt_sum[AMOUNT_W] ? AMOUNT_MAX : amt_sum[AMOUNT_W-1:0];
  assign tot_sum = {1'b0, res_value} + (VALUE_W + 1)'(ent_amt);
  assign tot_sat = (tot_sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : tot_sum[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= func_t'(func);
      q_src    <= in_src_key;
      q_dst    <= in_dst_key;
      q_amount <= amount;
    end
    scan_idx   <= scan_idx_next;
    res_src    <= res_src_next;
    res_dst    <= res_dst_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_hit    <= res_hit_next;
    if (out_load) begin
      out_src <= ID_W'(ld_src);
      out_dst <= ID_W'(ld_dst);
      value   <= ld_value;
      status  <= ld_status;
      last    <= ld_last;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_idx_next   = scan_idx;
    res_src_next    = res_src;
    res_dst_next    = res_dst;
    res_value_next  = res_value;
    res_status_next = res_status;
    res_hit_next    = res_hit;
    ram_raddr       = scan_idx;
    ram_we          = 1'b0;
    ram_waddr       = scan_idx;
    ram_wdata       = {ent_src, ent_dst, amt_sat};
    out_load        = 1'b0;
    ld_src          = res_src;
    ld_dst          = res_dst;
    ld_value        = res_value;
    ld_status       = res_status;
    ld_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        ram_raddr = '0;
        if (accept) begin
          scan_idx_next   = '0;
          res_src_next    = in_src_key;
          res_dst_next    = in_dst_key;
          res_value_next  = '0;
          res_status_next = ST_OK;
          res_hit_next    = 1'b0;
          state_next      = (count == '0) ? S_FINISH : S_SCAN;
          unique case (func_t'(func))
            FUNC_CLEAR: begin
              count_next   = '0;
              res_src_next = '0;
              res_dst_next = '0;
              state_next   = S_FINISH;
            end
            FUNC_ADD: begin
            end
            FUNC_LOOKUP, FUNC_LIST_SRC, FUNC_LIST_DST: begin
              res_status_next = ST_MISS;
            end
            FUNC_SUM_SRC: begin
              res_dst_next = '0;
            end
            FUNC_SUM_DST: begin
              res_src_next = '0;
            end
            FUNC_NOP: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        logic stop;
        logic consume;
        stop    = 1'b0;
        consume = 1'b1;
        unique case (op)
          FUNC_ADD: begin
            if (hit_src && hit_dst) begin
              ram_we       = 1'b1;
              res_hit_next = 1'b1;
              stop         = 1'b1;
            end
          end
          FUNC_LOOKUP: begin
            if (hit_src && hit_dst) begin
              res_value_next  = VALUE_W'(ent_amt);
              res_status_next = ST_OK;
              stop            = 1'b1;
            end
          end
          FUNC_LIST_SRC, FUNC_LIST_DST: begin
            if (hit_sel) begin
              if (res_hit && !out_free) begin
                consume = 1'b0;
              end else begin
                // The previous match is known not to be the last one now.
                out_load        = res_hit;
                ld_last         = 1'b0;
                res_src_next    = ent_src;
                res_dst_next    = ent_dst;
                res_value_next  = VALUE_W'(ent_amt);
                res_status_next = ST_OK;
                res_hit_next    = 1'b1;
              end
            end
          end
          FUNC_SUM_SRC, FUNC_SUM_DST: begin
            if (hit_sel) begin
              res_value_next = tot_sat;
            end
          end
          FUNC_CLEAR, FUNC_NOP: begin
            stop = 1'b1;
          end
        endcase
        if (stop) begin
          state_next = S_FINISH;
        end else if (consume) begin
          if (at_end) begin
            state_next = S_FINISH;
          end else begin
            scan_idx_next = scan_idx + IDX_W'(1);
            ram_raddr     = scan_idx + IDX_W'(1);
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (op == FUNC_ADD && !res_hit) begin
            if (count == DEPTH_CNT) begin
              ld_status = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = count[IDX_W-1:0];
              ram_wdata  = {q_src, q_dst, q_amount};
              count_next = count + CNT_W'(1);
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  // The scan only visits written entries.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> CNT_W'(scan_idx) < count)
    else $error("scan index beyond entry count");

  // A dropped add is reported only when the table is really full.
  a_full_when_full: assert property (@(posedge clk) disable iff (rst)
    out_load && ld_status == ST_FULL |-> count == DEPTH_CNT)
    else $error("full status with free rows");

  // An unused function code leaves the block idle with no result.
  a_nop_idle: assert property (@(posedge clk) disable iff (rst)
    accept && func_t'(func) == FUNC_NOP |=> state == S_IDLE && !out_load)
    else $error("unused function code started work");

endmodule

/* verif/pair_keyed_accumulate_table_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_keyed_accumulate_table_top_tb
// Self-checking bench for the pair-keyed accumulate table. A scoreboard keeps
// its own copy of the table, works out the results of every accepted word and
// compares each result word field by field. Stimulus is a directed opening,
// then random episodes: mixed traffic over small key pools, table fills up to
// and past full, and noise. Both sides idle at random, and the receiver holds
// off once for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module pair_keyed_accumulate_table_top_tb;
  import pkat_pkg::*;

  localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam int ID_BITS      = DEF_ID_BITS;
  localparam int CLK_PERIOD   = 4;
  localparam int WORD_TARGET  = 420;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [ID_W-1:0]    src;
    logic [ID_W-1:0]    dst;
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
    logic               last;
  } table_result_t;

  class pair_table_scoreboard;
    logic [ID_W-1:0]     key_src [TABLE_DEPTH];
    logic [ID_W-1:0]     key_dst [TABLE_DEPTH];
    logic [AMOUNT_W-1:0] stored_amount [TABLE_DEPTH];
    int                  entries;
    table_result_t       expected_q[$];
    int                  failures;

    function void enqueue(table_result_t r);
      expected_q = {expected_q, r};
    endfunction

    function void expect_result(logic [ID_W-1:0] s, logic [ID_W-1:0] d,
                                logic [VALUE_W-1:0] v, status_t st, logic l);
      table_result_t r;
      r.src    = s;
      r.dst    = d;
      r.value  = v;
      r.status = st;
      r.last   = l;
      enqueue(r);
    endfunction

    // Index of the pair in append order, or the entry count when absent.
    function int find_pair(logic [ID_W-1:0] s, logic [ID_W-1:0] d);
      for (int i = 0; i < entries; i++)
        if (key_src[i] == s && key_dst[i] == d) return i;
      return entries;
    endfunction

    function void note_word(func_t f, logic [ID_W-1:0] s_in, logic [ID_W-1:0] d_in,
                            logic [AMOUNT_W-1:0] amt);
      logic [ID_W-1:0]    id_mask;
      logic [ID_W-1:0]    s;
      logic [ID_W-1:0]    d;
      logic [AMOUNT_W:0]  acc;
      logic [VALUE_W:0]   total;
      int                 idx;
      bit                 by_src;
      bit                 hit;
      bit                 held;
      table_result_t      prev;
      id_mask = ID_W'((1 << ID_BITS) - 1);
      s = s_in & id_mask;
      d = d_in & id_mask;
      case (f)
        FUNC_CLEAR: begin
          entries = 0;
          expect_result('0, '0, '0, ST_OK, 1'b1);
        end
        FUNC_ADD: begin
          idx = find_pair(s, d);
          if (idx < entries) begin
            acc = {1'b0, stored_amount[idx]} + {1'b0, amt};
            stored_amount[idx] = (acc > {1'b0, AMOUNT_MAX}) ? AMOUNT_MAX : acc[AMOUNT_W-1:0];
            expect_result(s, d, '0, ST_OK, 1'b1);
          end else if (entries >= TABLE_DEPTH) begin
            expect_result(s, d, '0, ST_FULL, 1'b1);
          end else begin
            key_src[entries]       = s;
            key_dst[entries]       = d;
            stored_amount[entries] = amt;
            entries++;
            expect_result(s, d, '0, ST_OK, 1'b1);
          end
        end
        FUNC_LOOKUP: begin
          idx = find_pair(s, d);
          if (idx < entries)
            expect_result(s, d, VALUE_W'(stored_amount[idx]), ST_OK, 1'b1);
          else
            expect_result(s, d, '0, ST_MISS, 1'b1);
        end
        FUNC_LIST_SRC, FUNC_LIST_DST: begin
          by_src = (f == FUNC_LIST_SRC);
          held   = 1'b0;
          // Hold each match back one step so the final one can carry last.
          for (int i = 0; i < entries; i++) begin
            hit = by_src ? (key_src[i] == s) : (key_dst[i] == d);
            if (hit) begin
              if (held) enqueue(prev);
              prev.src    = key_src[i];
              prev.dst    = key_dst[i];
              prev.value  = VALUE_W'(stored_amount[i]);
              prev.status = ST_OK;
              prev.last   = 1'b0;
              held        = 1'b1;
            end
          end
          if (held) begin
            prev.last = 1'b1;
            enqueue(prev);
          end else begin
            expect_result(s, d, '0, ST_MISS, 1'b1);
          end
        end
        FUNC_SUM_SRC, FUNC_SUM_DST: begin
          by_src = (f == FUNC_SUM_SRC);
          total  = '0;
          for (int i = 0; i < entries; i++) begin
            hit = by_src ? (key_src[i] == s) : (key_dst[i] == d);
            if (hit) begin
              total = total + (VALUE_W + 1)'(stored_amount[i]);
              if (total > {1'b0, VALUE_MAX}) total = {1'b0, VALUE_MAX};
            end
          end
          expect_result(by_src ? s : '0, by_src ? '0 : d, total[VALUE_W-1:0], ST_OK, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(table_result_t act);
      table_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error({"result word with nothing pending: ",
                "out_src %0d out_dst %0d value %0d status %0d last %0d"},
               act.src, act.dst, act.value, act.status, act.last);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("out_src", 32'(exp_r.src),    32'(act.src));
      compare_field("out_dst", 32'(exp_r.dst),    32'(act.dst));
      compare_field("value",   32'(exp_r.value),  32'(act.value));
      compare_field("status",  32'(exp_r.status), 32'(act.status));
      compare_field("last",    32'(exp_r.last),   32'(act.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          func;
  logic [ID_W-1:0]     src_region;
  logic [ID_W-1:0]     dst_region;
  logic [AMOUNT_W-1:0] amount;
  logic                out_valid;
  logic                out_ready;
  logic [ID_W-1:0]     out_src;
  logic [ID_W-1:0]     out_dst;
  logic [VALUE_W-1:0]  value;
  logic [1:0]          status;
  logic                last;

  pair_table_scoreboard sb;
  int unsigned          cycle_count = 0;
  int                   words_sent  = 0;
  bit                   tx_burst    = 1'b0;

  pair_keyed_accumulate_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .src_region(src_region),
    .dst_region(dst_region),
    .amount    (amount),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_src   (out_src),
    .out_dst   (out_dst),
    .value     (value),
    .status    (status),
    .last      (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Results are checked before the word accepted at the same edge is noted,
  // since that word cannot have produced anything yet.
  always @(posedge clk) begin
    table_result_t seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.src    = out_src;
        seen.dst    = out_dst;
        seen.value  = value;
        seen.status = status;
        seen.last   = last;
        sb.check_result(seen);
      end
      if (in_valid && in_ready)
        sb.note_word(func_t'(func), src_region, dst_region, amount);
    end
  end

  // Receiver: a random pause after each accepted result, runs with no pauses,
  // and one long hold-off once enough results have gone by.
  initial begin
    int gap;
    int results_seen;
    int hold_left;
    bit hold_done;
    bit rx_burst;
    gap          = 0;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    rx_burst     = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        gap = rx_burst ? 0 : $urandom_range(0, 11);
        if (!hold_done && results_seen == HOLD_AFTER) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Valid stays up across back-to-back words; it only drops for a gap.
  task automatic send_word(func_t f, int s, int d, int a);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    src_region <= ID_W'(s);
    dst_region <= ID_W'(d);
    amount     <= AMOUNT_W'(a);
    do @(posedge clk); while (!in_ready);
    if (f != FUNC_NOP) words_sent++;
  endtask

  function automatic int pick_amount();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    int  src_pool [4];
    int  dst_pool [4];
    int  n_src;
    int  n_dst;
    int  kind;
    int  pick;
    int  s;
    int  d;
    int  base;
    bit  all_same;
    bit  first_episode;
    sb = new;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    func       <= FUNC_CLEAR;
    src_region <= '0;
    dst_region <= '0;
    amount     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty table, extremes of ids and amounts, saturation,
    // hits and misses of every query, the unused code, and clear.
    send_word(FUNC_CLEAR,    0,   0,   0);
    send_word(FUNC_LOOKUP,   5,   6,   0);
    send_word(FUNC_LIST_SRC, 5,   6,   0);
    send_word(FUNC_LIST_DST, 5,   6,   0);
    send_word(FUNC_SUM_SRC,  5,   6,   0);
    send_word(FUNC_SUM_DST,  5,   6,   0);
    send_word(FUNC_ADD,      0,   0,   0);
    send_word(FUNC_ADD,      255, 255, 65535);
    send_word(FUNC_ADD,      255, 255, 1);
    send_word(FUNC_ADD,      0,   255, 65535);
    send_word(FUNC_ADD,      255, 0,   1234);
    send_word(FUNC_ADD,      0,   0,   65535);
    send_word(FUNC_LOOKUP,   255, 255, 77);
    send_word(FUNC_LOOKUP,   0,   0,   0);
    send_word(FUNC_LOOKUP,   0,   1,   0);
    send_word(FUNC_LIST_SRC, 0,   9,   0);
    send_word(FUNC_LIST_DST, 9,   255, 0);
    send_word(FUNC_LIST_SRC, 7,   7,   0);
    send_word(FUNC_SUM_SRC,  255, 3,   0);
    send_word(FUNC_SUM_DST,  3,   0,   0);
    send_word(FUNC_SUM_DST,  3,   255, 0);
    send_word(FUNC_NOP,      255, 255, 65535);
    send_word(FUNC_CLEAR,    255, 255, 65535);
    send_word(FUNC_LOOKUP,   255, 255, 0);

    first_episode = 1'b1;
    while (words_sent < WORD_TARGET) begin
      kind = first_episode ? 6 : $urandom_range(0, 9);
      first_episode = 1'b0;
      for (int i = 0; i < 4; i++) begin
        src_pool[i] = $urandom_range(0, 255);
        dst_pool[i] = $urandom_range(0, 255);
      end
      if (kind <= 5) begin
        // Mixed traffic over a handful of keys so that adds merge and
        // queries mostly hit.
        if ($urandom_range(0, 1) == 1)
          send_word(FUNC_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), pick_amount());
        n_src = $urandom_range(1, 4);
        n_dst = $urandom_range(1, 4);
        repeat ($urandom_range(10, 30)) begin
          s    = src_pool[$urandom_range(0, n_src - 1)];
          d    = dst_pool[$urandom_range(0, n_dst - 1)];
          pick = $urandom_range(0, 99);
          if (pick < 40)      send_word(FUNC_ADD,      s, d, pick_amount());
          else if (pick < 55) send_word(FUNC_LOOKUP,   s, d, pick_amount());
          else if (pick < 65) send_word(FUNC_LIST_SRC, s, d, pick_amount());
          else if (pick < 75) send_word(FUNC_LIST_DST, s, d, pick_amount());
          else if (pick < 85) send_word(FUNC_SUM_SRC,  s, d, pick_amount());
          else if (pick < 95) send_word(FUNC_SUM_DST,  s, d, pick_amount());
          else send_word(func_t'($urandom_range(0, 7)), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 65535));
        end
      end else if (kind <= 7) begin
        // Fill the table with distinct pairs, push past full, then query.
        send_word(FUNC_CLEAR, 0, 0, 0);
        all_same = 1'($urandom_range(0, 1));
        base     = $urandom_range(0, 255);
        for (int k = 0; k < TABLE_DEPTH; k++)
          send_word(FUNC_ADD, all_same ? src_pool[0] : src_pool[k % 4],
                    (base + k) % 256, pick_amount());
        for (int j = 0; j < $urandom_range(1, 3); j++)
          send_word(FUNC_ADD, src_pool[0], (base + TABLE_DEPTH + j) % 256, pick_amount());
        send_word(FUNC_ADD,      src_pool[0], base, pick_amount());
        send_word(FUNC_LOOKUP,   src_pool[0], base, 0);
        send_word(FUNC_LOOKUP,   all_same ? src_pool[0] : src_pool[3], (base + 3) % 256, 0);
        send_word(FUNC_LOOKUP,   src_pool[0], (base + TABLE_DEPTH) % 256, 0);
        send_word(FUNC_LIST_SRC, src_pool[0], 0, 0);
        send_word(FUNC_LIST_DST, 0, (base + 5) % 256, 0);
        send_word(FUNC_SUM_SRC,  src_pool[1], 0, 0);
        send_word(FUNC_SUM_DST,  0, (base + 9) % 256, 0);
      end else begin
        repeat ($urandom_range(10, 20))
          send_word(func_t'($urandom_range(0, 7)), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 65535));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
